/* src/rbb_pkg.sv */
// rbb_pkg: shared types and constants for the rgb 3x3 box blur
// no dependencies
`default_nettype none

package rbb_pkg;

  localparam int MaxWidthDef = 2048;
  localparam int FilterSize  = 3;
  localparam int CfgW        = 12;
  localparam int ResetWidth  = 640;
  localparam int RowW        = 16;
  localparam int ChanW       = 8;
  // sum of nine 8-bit samples plus the rounding term stays below 4096
  localparam int SumW        = 12;
  // floor(x * 7282 / 2^16) == floor(x / 9) for every x below 32768
  localparam int Div9Mul     = 7282;
  localparam int Div9MulW    = 13;
  localparam int Div9Shift   = 16;
  localparam int RoundTerm   = 4;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_t;

  // one line store entry: newer line above the older line
  typedef struct packed {
    rgb_t newer;
    rgb_t older;
  } line_pair_t;

  typedef struct packed {
    logic [SumW-1:0] blue;
    logic [SumW-1:0] green;
    logic [SumW-1:0] red;
  } rgb_sum_t;

endpackage

`default_nettype wire

/* src/rbb_line_buf.sv */
// rbb_line_buf: two previous image lines in one memory, registered read
// depends on rbb_pkg
`default_nettype none

module rbb_line_buf #(
  parameter int MAX_WIDTH = rbb_pkg::MaxWidthDef,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire                    clk_i,
  input  wire                    rd_en_i,
  input  wire [COL_W-1:0]        rd_addr_i,
  input  wire                    wr_en_i,
  input  wire [COL_W-1:0]        wr_addr_i,
  input  rbb_pkg::line_pair_t    wr_data_i,
  output rbb_pkg::line_pair_t    rd_data_o
);

  rbb_pkg::line_pair_t mem_q [MAX_WIDTH];
  rbb_pkg::line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // back-to-back items on the same column (new frame right after column 0)
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* src/rbb_window.sv */
// rbb_window: 3x3 pixel window and per-channel neighbourhood sums
// depends on rbb_pkg
`default_nettype none

module rbb_window (
  input  wire                 clk_i,
  input  wire                 shift_i,
  input  rbb_pkg::rgb_t       top_i,
  input  rbb_pkg::rgb_t       mid_i,
  input  rbb_pkg::rgb_t       bot_i,
  output rbb_pkg::rgb_sum_t   sum_o
);

  localparam int N = rbb_pkg::FilterSize;

  rbb_pkg::rgb_t win_q [N][N];  // [row][col], col N-1 newest

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int r = 0; r < N; r++) begin
        for (int c = 0; c < N - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      win_q[0][N-1] <= top_i;
      win_q[1][N-1] <= mid_i;
      win_q[2][N-1] <= bot_i;
    end
  end

  always_comb begin
    sum_o = '0;
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        sum_o.red   = sum_o.red   + rbb_pkg::SumW'(win_q[r][c].red);
        sum_o.green = sum_o.green + rbb_pkg::SumW'(win_q[r][c].green);
        sum_o.blue  = sum_o.blue  + rbb_pkg::SumW'(win_q[r][c].blue);
      end
    end
  end

endmodule

`default_nettype wire

/* src/rbb_mean.sv */
// rbb_mean: registered sums, rounded divide by nine, output register
// depends on rbb_pkg
`default_nettype none

module rbb_mean #(
  parameter int MAX_WIDTH = rbb_pkg::MaxWidthDef,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  rbb_pkg::rgb_sum_t            in_sum_i,
  input  wire [rbb_pkg::RowW-1:0]      in_row_i,
  input  wire [COL_W-1:0]              in_col_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output rbb_pkg::rgb_t                out_rgb_o,
  output logic [rbb_pkg::RowW-1:0]     out_row_o,
  output logic [COL_W-1:0]             out_col_o
);

  localparam int ProdW = rbb_pkg::SumW + rbb_pkg::Div9MulW;

  logic                         sum_v_q;
  rbb_pkg::rgb_sum_t            sum_q;
  logic [rbb_pkg::RowW-1:0]     sum_row_q;
  logic [COL_W-1:0]             sum_col_q;
  logic                         out_v_q;
  rbb_pkg::rgb_t                out_rgb_q;
  logic [rbb_pkg::RowW-1:0]     out_row_q;
  logic [COL_W-1:0]             out_col_q;
  logic                         out_load;
  logic                         sum_load;
  rbb_pkg::rgb_t                mean_d;

  function automatic logic [rbb_pkg::ChanW-1:0] div9_round(
    input logic [rbb_pkg::SumW-1:0] sum
  );
    logic [ProdW-1:0] prod;
    prod = ProdW'(sum + rbb_pkg::SumW'(rbb_pkg::RoundTerm))
         * ProdW'(rbb_pkg::Div9Mul);
    return prod[rbb_pkg::Div9Shift +: rbb_pkg::ChanW];
  endfunction

  assign out_load   = sum_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !sum_v_q || out_load;
  assign sum_load   = in_valid_i && in_ready_o;

  always_comb begin
    mean_d.red   = div9_round(sum_q.red);
    mean_d.green = div9_round(sum_q.green);
    mean_d.blue  = div9_round(sum_q.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        sum_v_q <= in_valid_i;
      end
      if (!out_v_q || out_ready_i) begin
        out_v_q <= sum_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_load) begin
      sum_q     <= in_sum_i;
      sum_row_q <= in_row_i;
      sum_col_q <= in_col_i;
    end
    if (out_load) begin
      out_rgb_q <= mean_d;
      out_row_q <= sum_row_q;
      out_col_q <= sum_col_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rgb_o   = out_rgb_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

endmodule

`default_nettype wire

/* src/rgb_box_blur_3x3.sv */
// rgb_box_blur_3x3: streaming 3x3 mean filter on interleaved rgb pixels
// path: a result word leaves once its center's lower-right pixel is accepted and
// has passed the line store read, window, sums, divide and output registers
// throughput: one pixel word per cycle while the result side is ready; once the
// stages hold waiting words, an output stall holds the input in the same cycle
// reset: asynchronous active low; clears position, stage valids, width = 640
// depends on rbb_pkg, rbb_line_buf, rbb_window, rbb_mean
`default_nettype none

module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH = rbb_pkg::MaxWidthDef,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int OUT_BITS = 3 * rbb_pkg::ChanW + rbb_pkg::RowW + COL_W,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [rbb_pkg::CfgW-1:0]  cfg_wdata_i,   // image_width
  input  wire                      s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire [23:0]               s_axis_tdata_i, // red_in, green_in, blue_in
  input  wire                      s_axis_tuser_i, // first_pixel
  output logic                     m_axis_tvalid_o,
  input  wire                      m_axis_tready_i,
  // red_out, green_out, blue_out, center_row, center_col, zero fill
  output logic [OUT_W-1:0]         m_axis_tdata_o
);

  localparam int EW   = COL_W + 1;
  localparam int RowW = rbb_pkg::RowW;

  logic [rbb_pkg::CfgW-1:0] width_q;
  logic [COL_W-1:0]         col_cnt_q;
  logic [RowW-1:0]          row_cnt_q;
  logic [EW-1:0]            eff_w;
  logic [COL_W-1:0]         col_raw;
  logic [COL_W-1:0]         col_pos;
  logic [RowW-1:0]          row_pos;
  logic [EW-1:0]            col_inc;
  logic                     accept;

  // stage 1: pixel waiting for its line store read
  logic                     s1_v_q;
  rbb_pkg::rgb_t            s1_pix_q;
  logic [COL_W-1:0]         s1_col_q;
  logic                     s1_emit_q;
  logic [RowW-1:0]          s1_crow_q;
  logic [COL_W-1:0]         s1_ccol_q;
  logic                     s1_adv;

  // stage 2: window holds the neighbourhood of a pending center
  logic                     s2_v_q;
  logic [RowW-1:0]          s2_crow_q;
  logic [COL_W-1:0]         s2_ccol_q;
  logic                     s2_adv;

  rbb_pkg::line_pair_t      rd_pair;
  rbb_pkg::line_pair_t      wr_pair;
  rbb_pkg::rgb_sum_t        win_sum;
  logic                     mean_ready;
  rbb_pkg::rgb_t            out_rgb;
  logic [RowW-1:0]          out_row;
  logic [COL_W-1:0]         out_col;

  always_comb begin
    if (width_q < rbb_pkg::CfgW'(rbb_pkg::FilterSize)) begin
      eff_w = EW'(rbb_pkg::FilterSize);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
  end

  always_comb begin
    col_raw = s_axis_tuser_i ? '0 : col_cnt_q;
    row_pos = s_axis_tuser_i ? '0 : row_cnt_q;
    // width shrunk below the current column
    if ({1'b0, col_raw} >= eff_w) begin
      col_pos = COL_W'(eff_w - EW'(1));
    end else begin
      col_pos = col_raw;
    end
    col_inc = {1'b0, col_pos} + EW'(1);
  end

  assign s2_adv          = s2_v_q && mean_ready;
  assign s1_adv          = s1_v_q && (!s2_v_q || s2_adv);
  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= rbb_pkg::CfgW'(rbb_pkg::ResetWidth);
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (col_inc >= eff_w) begin
          col_cnt_q <= '0;
          row_cnt_q <= row_pos + RowW'(1);
        end else begin
          col_cnt_q <= col_inc[COL_W-1:0];
          row_cnt_q <= row_pos;
        end
      end
      if (s_axis_tready_o) begin
        s1_v_q <= s_axis_tvalid_i;
      end
      if (s1_adv) begin
        s2_v_q <= s1_emit_q;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata_i;
      s1_col_q  <= col_pos;
      s1_emit_q <= (row_pos >= RowW'(2)) && (col_pos >= COL_W'(2));
      s1_crow_q <= row_pos - RowW'(1);
      s1_ccol_q <= col_pos - COL_W'(1);
    end
    if (s1_adv) begin
      s2_crow_q <= s1_crow_q;
      s2_ccol_q <= s1_ccol_q;
    end
  end

  // older line takes the newer entry, newer line takes the pixel
  always_comb begin
    wr_pair.newer = s1_pix_q;
    wr_pair.older = rd_pair.newer;
  end

  rbb_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_pos),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_pair),
    .rd_data_o (rd_pair)
  );

  rbb_window u_window (
    .clk_i   (clk_i),
    .shift_i (s1_adv),
    .top_i   (rd_pair.older),
    .mid_i   (rd_pair.newer),
    .bot_i   (s1_pix_q),
    .sum_o   (win_sum)
  );

  rbb_mean #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (mean_ready),
    .in_sum_i    (win_sum),
    .in_row_i    (s2_crow_q),
    .in_col_i    (s2_ccol_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rgb_o   (out_rgb),
    .out_row_o   (out_row),
    .out_col_o   (out_col)
  );

  assign m_axis_tdata_o = OUT_W'({out_col, out_row, out_rgb});

endmodule

`default_nettype wire
